[hw/rtl/mbsg_pkg.sv]
// Shared types, codes and helpers for the multi-buffer swap guard.
// No dependencies; every other RTL file of the block imports this package.
`default_nettype none

package mbsg_pkg;

  localparam int unsigned MAX_BUFFERS_DEF = 4;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned COUNT_W  = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 3;

  localparam logic [COUNT_W-1:0] BUFFER_COUNT_RST = 3'd3;

  typedef enum logic [2:0] {
    BUF_EMPTY   = 3'd0,
    BUF_READING = 3'd1,
    BUF_READ    = 3'd2,
    BUF_WRITING = 3'd3,
    BUF_WRITTEN = 3'd4
  } buf_state_e;

  typedef enum logic [OP_W-1:0] {
    OP_ACQ_READ  = 2'd0,
    OP_ACQ_WRITE = 2'd1,
    OP_FINISH    = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_NONE  = 2'd1,
    STAT_ERROR = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUFFER_COUNT    = 2'd0,
    CFG_REPEATED_READS  = 2'd1,
    CFG_REPEATED_WRITES = 2'd2
  } cfg_reg_e;

  // Read and write positions of the ring.
  typedef struct packed {
    logic [IDX_W-1:0] rd_pos;
    logic [IDX_W-1:0] wr_pos;
  } ring_pos_t;

  // One response.
  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] index;
  } resp_t;

  // (pos + 1) mod count for count in 2..4 and pos in 0..3; the sum is at
  // most 4, so two conditional subtracts cover every case.
  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0]   pos,
                                                 input logic [COUNT_W-1:0] count);
    logic [COUNT_W-1:0] t;
    t = {1'b0, pos} + COUNT_W'(1);
    if (t >= count) begin
      t = t - count;
    end
    if (t >= count) begin
      t = t - count;
    end
    return t[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/mbsg_decide.sv]
// Combinational decision logic: evaluates one request against the buffer states,
// ring positions and configuration. Depends on mbsg_pkg.
`default_nettype none

module mbsg_decide #(
  parameter int unsigned MAX_BUFFERS = mbsg_pkg::MAX_BUFFERS_DEF
) (
  input  logic [mbsg_pkg::OP_W-1:0]                 op_i,
  input  logic [mbsg_pkg::IDX_W-1:0]                buffer_index_i,
  input  logic [mbsg_pkg::COUNT_W-1:0]              buffer_count_i,
  input  logic                                      repeated_reads_i,
  input  logic                                      repeated_writes_i,
  input  mbsg_pkg::buf_state_e [MAX_BUFFERS-1:0]    slots_i,
  input  mbsg_pkg::ring_pos_t                       pos_i,
  output mbsg_pkg::buf_state_e [MAX_BUFFERS-1:0]    slots_o,
  output mbsg_pkg::ring_pos_t                       pos_o,
  output mbsg_pkg::resp_t                           resp_o
);
  import mbsg_pkg::*;

  // Entries past the array read as empty.
  function automatic buf_state_e slot_at(input logic [IDX_W-1:0] p,
                                         input buf_state_e [MAX_BUFFERS-1:0] s);
    buf_state_e r;
    r = BUF_EMPTY;
    for (int i = 0; i < MAX_BUFFERS; i++) begin
      if (p == IDX_W'(i)) begin
        r = s[i];
      end
    end
    return r;
  endfunction

  logic [IDX_W-1:0] rd_next, wr_next, tgt;
  buf_state_e       s_rd_next, s_rd_cur, s_wr_next, s_wr_cur, s_fin, tgt_val;
  logic             any_reading, any_writing, cfg_ok, do_set;

  always_comb begin
    rd_next   = ring_next(pos_i.rd_pos, buffer_count_i);
    wr_next   = ring_next(pos_i.wr_pos, buffer_count_i);
    s_rd_next = slot_at(rd_next, slots_i);
    s_rd_cur  = slot_at(pos_i.rd_pos, slots_i);
    s_wr_next = slot_at(wr_next, slots_i);
    s_wr_cur  = slot_at(pos_i.wr_pos, slots_i);
    s_fin     = slot_at(buffer_index_i, slots_i);

    any_reading = 1'b0;
    any_writing = 1'b0;
    for (int i = 0; i < MAX_BUFFERS; i++) begin
      if (COUNT_W'(i) < buffer_count_i) begin
        if (slots_i[i] == BUF_READING) begin
          any_reading = 1'b1;
        end
        if (slots_i[i] == BUF_WRITING) begin
          any_writing = 1'b1;
        end
      end
    end

    cfg_ok = (buffer_count_i >= COUNT_W'(2)) &&
             (buffer_count_i <= COUNT_W'(MAX_BUFFERS)) &&
             (buffer_count_i > (COUNT_W'(1) + COUNT_W'(repeated_reads_i) +
                                COUNT_W'(repeated_writes_i)));

    pos_o        = pos_i;
    resp_o       = '{status: STAT_NONE, index: '0};
    do_set       = 1'b0;
    tgt          = '0;
    tgt_val      = BUF_EMPTY;

    case (op_e'(op_i))
      OP_ACQ_READ: begin
        if (any_reading) begin
          resp_o.status = STAT_ERROR;
        end else if (s_rd_next == BUF_WRITTEN &&
                     (!repeated_reads_i || rd_next != pos_i.wr_pos)) begin
          pos_o.rd_pos  = rd_next;
          do_set        = 1'b1;
          tgt           = rd_next;
          tgt_val       = BUF_READING;
          resp_o.status = STAT_OK;
          resp_o.index  = rd_next;
        end else if (repeated_reads_i && s_rd_cur == BUF_READ) begin
          do_set        = 1'b1;
          tgt           = pos_i.rd_pos;
          tgt_val       = BUF_READING;
          resp_o.status = STAT_OK;
          resp_o.index  = pos_i.rd_pos;
        end
      end
      OP_ACQ_WRITE: begin
        if (any_writing) begin
          resp_o.status = STAT_ERROR;
        end else if (s_wr_next == BUF_EMPTY ||
                     (s_wr_next == BUF_READ &&
                      (!repeated_writes_i || wr_next != pos_i.rd_pos))) begin
          pos_o.wr_pos  = wr_next;
          do_set        = 1'b1;
          tgt           = wr_next;
          tgt_val       = BUF_WRITING;
          resp_o.status = STAT_OK;
          resp_o.index  = wr_next;
        end else if (repeated_writes_i && s_wr_cur == BUF_WRITTEN) begin
          do_set        = 1'b1;
          tgt           = pos_i.wr_pos;
          tgt_val       = BUF_WRITING;
          resp_o.status = STAT_OK;
          resp_o.index  = pos_i.wr_pos;
        end
      end
      OP_FINISH: begin
        tgt = buffer_index_i;
        if ({1'b0, buffer_index_i} >= buffer_count_i) begin
          resp_o.status = STAT_ERROR;
        end else if (s_fin == BUF_READING) begin
          do_set        = 1'b1;
          tgt_val       = BUF_READ;
          resp_o.status = STAT_OK;
        end else if (s_fin == BUF_WRITING) begin
          do_set        = 1'b1;
          tgt_val       = BUF_WRITTEN;
          resp_o.status = STAT_OK;
        end else begin
          resp_o.status = STAT_ERROR;
        end
      end
      default: begin
        resp_o.status = STAT_ERROR;
      end
    endcase

    // Bad configuration: error, nothing changes.
    if (!cfg_ok) begin
      pos_o         = pos_i;
      do_set        = 1'b0;
      resp_o.status = STAT_ERROR;
      resp_o.index  = '0;
    end

    slots_o = slots_i;
    for (int i = 0; i < MAX_BUFFERS; i++) begin
      if (do_set && tgt == IDX_W'(i)) begin
        slots_o[i] = tgt_val;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/multi_buffer_swap_guard.sv]
// Top level of the multi-buffer swap guard: request register, ring state,
// configuration and response register. Depends on mbsg_pkg and mbsg_decide.
`default_nettype none

// Usage
//   Request channel: drive op_i / buffer_index_i with start_i high; the
//   transfer happens at the rising edge where start_i is high and busy_o is
//   low. busy_o is always low: one request can be taken every cycle.
//   Response channel: done_o is high for exactly one cycle with status_o and
//   granted_index_o; that cycle is the transfer, the receiver cannot stall.
//   Response path: the request is captured in the request register at the
//   accepting edge, evaluated against the ring state in the next cycle, and
//   the response is then registered in the response register.
//   Throughput: one request per cycle; the state update for a request lands
//   at the same edge as its response, so back-to-back requests see it.
//   Configuration: cfg_we_i / cfg_index_i / cfg_data_i write one register per
//   edge (0 buffer_count, 1 repeated_reads, 2 repeated_writes); write only
//   while no request is in flight. Other indexes are ignored.
//   Reset (rst_ni low, asynchronous): all buffers empty, both positions 0,
//   buffer_count 3, repeated reads and writes off, nothing in flight.
module multi_buffer_swap_guard #(
  parameter int unsigned MAX_BUFFERS = mbsg_pkg::MAX_BUFFERS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [mbsg_pkg::OP_W-1:0]         op_i,
  input  logic [mbsg_pkg::IDX_W-1:0]        buffer_index_i,
  output logic                              done_o,
  output logic [mbsg_pkg::STATUS_W-1:0]     status_o,
  output logic [mbsg_pkg::IDX_W-1:0]        granted_index_o,
  input  logic                              cfg_we_i,
  input  logic [mbsg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mbsg_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import mbsg_pkg::*;

  // Request register
  logic              req_valid_q;
  logic [OP_W-1:0]   req_op_q;
  logic [IDX_W-1:0]  req_idx_q;

  // Configuration
  logic [COUNT_W-1:0] buffer_count_q;
  logic               repeated_reads_q;
  logic               repeated_writes_q;

  // Ring state
  buf_state_e [MAX_BUFFERS-1:0] slots_q, slots_d;
  ring_pos_t                    pos_q, pos_d;

  // Response register
  logic   done_q;
  resp_t  resp_q, resp_d;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start_i && !busy_o;
    end
  end

  // Payload only, no reset needed.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_op_q  <= op_i;
      req_idx_q <= buffer_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_count_q    <= BUFFER_COUNT_RST;
      repeated_reads_q  <= 1'b0;
      repeated_writes_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_BUFFER_COUNT:    buffer_count_q    <= cfg_data_i[COUNT_W-1:0];
        CFG_REPEATED_READS:  repeated_reads_q  <= cfg_data_i[0];
        CFG_REPEATED_WRITES: repeated_writes_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  mbsg_decide #(
    .MAX_BUFFERS (MAX_BUFFERS)
  ) u_decide (
    .op_i              (req_op_q),
    .buffer_index_i    (req_idx_q),
    .buffer_count_i    (buffer_count_q),
    .repeated_reads_i  (repeated_reads_q),
    .repeated_writes_i (repeated_writes_q),
    .slots_i           (slots_q),
    .pos_i             (pos_q),
    .slots_o           (slots_d),
    .pos_o             (pos_d),
    .resp_o            (resp_d)
  );

  // State commits together with the response of the request in evaluation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= '{default: BUF_EMPTY};
      pos_q   <= '0;
    end else if (req_valid_q) begin
      slots_q <= slots_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      resp_q <= resp_d;
    end
  end

  assign done_o          = done_q;
  assign status_o        = resp_q.status;
  assign granted_index_o = resp_q.index;

endmodule

`default_nettype wire

[hw/rtl/mbsg_checker.sv]
// Port-level checker for multi_buffer_swap_guard, bound to the top level.
// Depends on mbsg_pkg.
`default_nettype none

module mbsg_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start_i,
  input logic                            busy_o,
  input logic [mbsg_pkg::OP_W-1:0]       op_i,
  input logic                            done_o,
  input logic [mbsg_pkg::STATUS_W-1:0]   status_o,
  input logic [mbsg_pkg::IDX_W-1:0]      granted_index_o
);
  import mbsg_pkg::*;

  // Every accepted request answers with done_o after the request and response registers.
  a_resp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 done_o)
    else $error("request transfer without response");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("response without request transfer");

  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STAT_OK) |-> granted_index_o == '0)
    else $error("index on refused or failed request");

  a_finish_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(op_i, 2) == OP_FINISH) |-> granted_index_o == '0)
    else $error("index on finish response");

  a_bad_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(op_i, 2) != OP_ACQ_READ && $past(op_i, 2) != OP_ACQ_WRITE &&
     $past(op_i, 2) != OP_FINISH) |-> status_o == STAT_ERROR)
    else $error("unknown op not reported as error");

endmodule

bind multi_buffer_swap_guard mbsg_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .op_i            (op_i),
  .done_o          (done_o),
  .status_o        (status_o),
  .granted_index_o (granted_index_o)
);

`default_nettype wire

[bench/multi_buffer_swap_guard_test.sv]
// Self-checking bench for multi_buffer_swap_guard: directed and random
// requests with a scoreboard that predicts every response. Depends on mbsg_pkg.
`default_nettype none

module multi_buffer_swap_guard_test;
  import mbsg_pkg::*;

  // op 3 has no package code; the block must answer it with an error
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
  localparam int unsigned     PHASES     = 7;
  localparam int unsigned     PHASE_ITEMS = 250;

  // Scoreboard: keeps its own copy of the ring and the registers, predicts
  // the response of each accepted request and checks the responses in order.
  class swap_guard_scoreboard;
    buf_state_e         slot_st [MAX_BUFFERS_DEF];
    logic [IDX_W-1:0]   rd_pos;
    logic [IDX_W-1:0]   wr_pos;
    logic [COUNT_W-1:0] buf_count;
    logic               rep_reads;
    logic               rep_writes;
    resp_t              expected_resps [$];
    int unsigned        fail_count;

    function new();
      foreach (slot_st[i]) slot_st[i] = BUF_EMPTY;
      rd_pos     = '0;
      wr_pos     = '0;
      buf_count  = BUFFER_COUNT_RST;
      rep_reads  = 1'b0;
      rep_writes = 1'b0;
      fail_count = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_BUFFER_COUNT:    buf_count  = data;
        CFG_REPEATED_READS:  rep_reads  = data[0];
        CFG_REPEATED_WRITES: rep_writes = data[0];
        default: ;
      endcase
    endfunction

    function bit config_ok();
      if (buf_count < 2 || buf_count > MAX_BUFFERS_DEF) return 1'b0;
      return buf_count > 1 + rep_reads + rep_writes;
    endfunction

    // Busy checks only look at buffers inside the current count.
    function bit in_use_as(buf_state_e st);
      for (int i = 0; i < buf_count && i < MAX_BUFFERS_DEF; i++)
        if (slot_st[i] == st) return 1'b1;
      return 1'b0;
    endfunction

    function logic [IDX_W-1:0] next_pos(logic [IDX_W-1:0] pos);
      int t;
      t = (int'(pos) + 1) % int'(buf_count);
      return IDX_W'(t);
    endfunction

    function resp_t predict_response(logic [OP_W-1:0] op, logic [IDX_W-1:0] bi);
      resp_t            r;
      logic [IDX_W-1:0] n;
      r.status = STAT_ERROR;
      r.index  = '0;
      if (!config_ok()) return r;
      case (op)
        OP_ACQ_READ: begin
          if (in_use_as(BUF_READING)) return r;
          n = next_pos(rd_pos);
          if (slot_st[n] == BUF_WRITTEN && (!rep_reads || n != wr_pos)) begin
            rd_pos     = n;
            slot_st[n] = BUF_READING;
            r.status   = STAT_OK;
            r.index    = n;
          end else if (rep_reads && slot_st[rd_pos] == BUF_READ) begin
            // reread of the last read buffer
            slot_st[rd_pos] = BUF_READING;
            r.status        = STAT_OK;
            r.index         = rd_pos;
          end else begin
            r.status = STAT_NONE;
          end
        end
        OP_ACQ_WRITE: begin
          if (in_use_as(BUF_WRITING)) return r;
          n = next_pos(wr_pos);
          if (slot_st[n] == BUF_EMPTY ||
              (slot_st[n] == BUF_READ && (!rep_writes || n != rd_pos))) begin
            wr_pos     = n;
            slot_st[n] = BUF_WRITING;
            r.status   = STAT_OK;
            r.index    = n;
          end else if (rep_writes && slot_st[wr_pos] == BUF_WRITTEN) begin
            // rewrite of the last written buffer
            slot_st[wr_pos] = BUF_WRITING;
            r.status        = STAT_OK;
            r.index         = wr_pos;
          end else begin
            r.status = STAT_NONE;
          end
        end
        OP_FINISH: begin
          if (bi >= buf_count) return r;
          if (slot_st[bi] == BUF_READING) begin
            slot_st[bi] = BUF_READ;
            r.status    = STAT_OK;
          end else if (slot_st[bi] == BUF_WRITING) begin
            slot_st[bi] = BUF_WRITTEN;
            r.status    = STAT_OK;
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] bi);
      expected_resps.push_back(predict_response(op, bi));
    endfunction

    function void check_response(logic [STATUS_W-1:0] st, logic [IDX_W-1:0] gi);
      resp_t e;
      if (expected_resps.size() == 0) begin
        $display("%0t: response with nothing expected, status %0d index %0d",
                 $time, st, gi);
        fail_count++;
        return;
      end
      e = expected_resps.pop_front();
      if (st !== e.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, e.status, st);
        fail_count++;
      end
      if (gi !== e.index) begin
        $display("%0t: granted_index mismatch, expected %0d, actual %0d",
                 $time, e.index, gi);
        fail_count++;
      end
    endfunction

    function int unsigned pending();
      return expected_resps.size();
    endfunction

    // Pick a buffer that is currently held (reading or writing), if any.
    function bit pick_held(output logic [IDX_W-1:0] bi);
      int cands [$];
      bi = '0;
      for (int i = 0; i < buf_count && i < MAX_BUFFERS_DEF; i++)
        if (slot_st[i] == BUF_READING || slot_st[i] == BUF_WRITING) cands.push_back(i);
      if (cands.size() == 0) return 1'b0;
      bi = IDX_W'(cands[$urandom_range(cands.size() - 1)]);
      return 1'b1;
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni          = 1'b0;
  logic                  start_i         = 1'b0;
  logic [OP_W-1:0]       op_i            = '0;
  logic [IDX_W-1:0]      buffer_index_i  = '0;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;
  logic                  busy_o;
  logic                  done_o;
  logic [STATUS_W-1:0]   status_o;
  logic [IDX_W-1:0]      granted_index_o;

  swap_guard_scoreboard sb;

  multi_buffer_swap_guard u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .op_i            (op_i),
    .buffer_index_i  (buffer_index_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .granted_index_o (granted_index_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Monitor: everything is sampled at the rising edge, inputs change at the
  // falling edge. The response is checked before the new request is noted;
  // a response always belongs to an older request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_response(status_o, granted_index_o);
      if (start_i && !busy_o) sb.note_request(op_i, buffer_index_i);
    end
  end

  // Called and returns at a falling edge. Idle cycles are drawn per cycle
  // with idle_pct percent. start_i stays high across back-to-back transfers.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] bi,
                              input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i        <= 1'b1;
    op_i           <= op;
    buffer_index_i <= bi;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Finish whatever buffer is held; a random index if none is.
  task automatic send_finish_held(input int unsigned idle_pct);
    logic [IDX_W-1:0] bi;
    if (!sb.pick_held(bi)) bi = IDX_W'($urandom_range(3));
    send_request(OP_FINISH, bi, idle_pct);
  endtask

  // Stop sending and wait for every outstanding response, plus latency slack.
  task automatic drain();
    int unsigned n;
    n = 0;
    start_i <= 1'b0;
    while (sb.pending() != 0 && n < 100) begin
      @(negedge clk_i);
      n++;
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_beat(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // Only called with the block idle. Flag registers get random upper bits,
  // which the block must ignore.
  task automatic set_config(input logic [CFG_DATA_W-1:0] count, input logic rr,
                            input logic rw);
    cfg_we_i <= 1'b1;
    cfg_beat(CFG_BUFFER_COUNT, count);
    cfg_beat(CFG_REPEATED_READS, {2'($urandom_range(3)), rr});
    cfg_beat(CFG_REPEATED_WRITES, {2'($urandom_range(3)), rw});
    cfg_we_i <= 1'b0;
  endtask

  // Mostly well-formed producer/consumer traffic, with some noise.
  task automatic run_phase(input int unsigned items, input int unsigned idle_pct,
                           input bit pause_midway);
    int unsigned r;
    for (int unsigned k = 0; k < items; k++) begin
      if (pause_midway && k == items / 2) drain();
      r = $urandom_range(99);
      if (r < 10) begin
        send_request(OP_W'($urandom_range(3)), IDX_W'($urandom_range(3)), idle_pct);
      end else if (r < 40) begin
        send_request(OP_ACQ_READ, IDX_W'($urandom_range(3)), idle_pct);
      end else if (r < 70) begin
        send_request(OP_ACQ_WRITE, IDX_W'($urandom_range(3)), idle_pct);
      end else begin
        send_finish_held(idle_pct);
      end
    end
  endtask

  initial begin
    int unsigned      idle_tab [PHASES];
    logic [COUNT_W-1:0] cnt_tab [PHASES];
    logic             rr_tab [PHASES];
    logic             rw_tab [PHASES];

    idle_tab = '{0, 68, 7, 0, 68, 7, 0};
    cnt_tab  = '{3, 2, 4, 4, 3, 4, 2};
    rr_tab   = '{0, 0, 1, 1, 0, 0, 0};
    rw_tab   = '{0, 0, 1, 0, 1, 1, 0};
    sb = new();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset configuration, busy errors, finish errors, unknown op.
    send_request(OP_ACQ_READ, 2'd0, 0);
    send_request(OP_ACQ_WRITE, 2'd3, 0);
    send_request(OP_ACQ_WRITE, 2'd0, 0);
    send_request(OP_FINISH, 2'd0, 0);
    send_request(OP_FINISH, 2'd3, 0);
    send_request(OP_FINISH, 2'd1, 0);
    send_request(OP_ACQ_READ, 2'd0, 0);
    send_request(OP_ACQ_READ, 2'd3, 0);
    send_request(OP_UNKNOWN, 2'd3, 0);
    send_request(OP_FINISH, 2'd1, 0);
    send_request(OP_ACQ_WRITE, 2'd0, 0);
    send_request(OP_FINISH, 2'd2, 0);
    send_request(OP_ACQ_WRITE, 2'd0, 0);
    send_request(OP_FINISH, 2'd0, 0);
    drain();
    // count below range, then count too small for both repeat modes
    set_config(3'd1, 1'b0, 1'b0);
    send_request(OP_ACQ_READ, 2'd0, 0);
    drain();
    set_config(3'd3, 1'b1, 1'b1);
    send_request(OP_FINISH, 2'd0, 0);
    drain();
    // largest ring with rereads and rewrites
    set_config(3'd4, 1'b1, 1'b1);
    send_request(OP_ACQ_WRITE, 2'd0, 0);
    send_finish_held(0);
    send_request(OP_ACQ_READ, 2'd0, 0);
    send_finish_held(0);
    send_request(OP_ACQ_READ, 2'd0, 0);
    send_finish_held(0);
    send_request(OP_ACQ_WRITE, 2'd0, 0);
    send_finish_held(0);
    send_request(OP_ACQ_WRITE, 2'd0, 0);
    send_request(OP_FINISH, 2'd3, 0);
    drain();

    // Random phases. Buffer states carry over, so count changes land on a
    // ring that is still in use.
    for (int p = 0; p < PHASES; p++) begin
      if (p == 5) set_config(3'($urandom_range(7)), 1'($urandom_range(1)),
                             1'($urandom_range(1)));
      else set_config(cnt_tab[p], rr_tab[p], rw_tab[p]);
      run_phase(PHASE_ITEMS, idle_tab[p], p == 3);
      drain();
    end

    if (sb.pending() != 0) begin
      $display("%0t: %0d responses never arrived", $time, sb.pending());
      sb.fail_count++;
    end
    if (sb.fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("%0t: timeout", $time);
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

[multi_buffer_swap_guard.f]
hw/rtl/mbsg_pkg.sv
hw/rtl/mbsg_decide.sv
hw/rtl/multi_buffer_swap_guard.sv
hw/rtl/mbsg_checker.sv
bench/multi_buffer_swap_guard_test.sv
